/* design/tcw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg - shared types and constants for the text console character writer
// Screen geometry, control codes, field widths and the item type passed from
// the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;

  // Field and state widths
  localparam int CODE_W = 8;
  localparam int ATTR_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int IDX_W  = 11;
  // Full width of row * COLUMNS + column before truncation to IDX_W
  localparam int LIN_W  = ROW_W + COL_W;

  // Control codes
  localparam logic [CODE_W-1:0] CODE_NEWLINE   = 8'd10;
  localparam logic [CODE_W-1:0] CODE_BACKSPACE = 8'd8;
  localparam logic [CODE_W-1:0] CODE_SPACE     = 8'd32;

  // Attribute after reset
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Item class decided by the front end
  typedef enum logic [1:0] {
    OP_PRINT,
    OP_NEWLINE,
    OP_BACKSPACE
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CODE_W-1:0] code;
  } item_t;

  // Handshake between queue and back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_out_t;

endpackage

/* design/tcw_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_front - input front end
// Takes character items, classifies them as print, newline or backspace and
// pushes them into the queue; stalls the source while the queue is full.
// ----------------------------------------------------------------------------
module tcw_front (
  input  logic                      char_valid,
  output logic                      char_stall,
  input  logic [tcw_pkg::CODE_W-1:0] char_code,
  input  logic                      q_full,
  output logic                      q_push,
  output tcw_pkg::item_t            q_item
);

  // Classify the incoming code
  always_comb begin
    q_item.code = char_code;
    priority if (char_code == tcw_pkg::CODE_NEWLINE) begin
      q_item.op = tcw_pkg::OP_NEWLINE;
    end else if (char_code == tcw_pkg::CODE_BACKSPACE) begin
      q_item.op = tcw_pkg::OP_BACKSPACE;
    end else begin
      q_item.op = tcw_pkg::OP_PRINT;
    end
  end

  // Accept whenever the queue has room
  assign char_stall = q_full;
  assign q_push     = char_valid && !q_full;

endmodule

/* design/tcw_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_queue - short item queue between front and back end
// Register-based FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module tcw_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tcw_pkg::item_t  push_item,
  output logic            full,
  input  logic            pop,
  output tcw_pkg::q_out_t head
);

  tcw_pkg::item_t              entries [tcw_pkg::QUEUE_DEPTH];
  logic [tcw_pkg::QPTR_W-1:0]  wr_ptr;
  logic [tcw_pkg::QPTR_W-1:0]  rd_ptr;
  logic [tcw_pkg::QCNT_W-1:0]  count;
  logic                        do_pop;

  assign full       = (count == tcw_pkg::QCNT_W'(tcw_pkg::QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.item  = entries[rd_ptr];
  assign do_pop     = pop && head.valid;

  // Pointer wrap
  function automatic logic [tcw_pkg::QPTR_W-1:0] ptr_inc(
    input logic [tcw_pkg::QPTR_W-1:0] p
  );
    if (p == tcw_pkg::QPTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + tcw_pkg::QPTR_W'(1);
  endfunction

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      unique case ({push, do_pop})
        2'b10:   count <= count + tcw_pkg::QCNT_W'(1);
        2'b01:   count <= count - tcw_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* design/tcw_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_back - cursor engine and result register
// Pops classified items, updates the cursor, forms the cell write and the new
// cursor position, and holds the result in an output register. Also holds the
// text attribute register.
// ----------------------------------------------------------------------------
module tcw_back (
  input  logic                       clk,
  input  logic                       rst,
  input  tcw_pkg::q_out_t            head,
  output logic                       pop,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [tcw_pkg::ATTR_W-1:0] text_attribute,
  output logic                       res_valid,
  input  logic                       res_stall,
  output logic                       write_valid,
  output logic [tcw_pkg::IDX_W-1:0]  cell_index,
  output logic [tcw_pkg::CODE_W-1:0] glyph,
  output logic [tcw_pkg::ATTR_W-1:0] attribute,
  output logic                       clear_request,
  output logic [tcw_pkg::IDX_W-1:0]  cursor_position
);

  logic [tcw_pkg::ATTR_W-1:0] attr_reg;
  logic [tcw_pkg::ROW_W-1:0]  cursor_row;
  logic [tcw_pkg::COL_W-1:0]  cursor_column;

  // Working values, one bit wider for the step past the edge
  logic [tcw_pkg::ROW_W:0]    row_step;
  logic [tcw_pkg::COL_W:0]    col_step;
  logic [tcw_pkg::ROW_W-1:0]  cursor_row_next;
  logic [tcw_pkg::COL_W-1:0]  cursor_column_next;
  logic                       wr;
  logic                       clr;
  logic [tcw_pkg::CODE_W-1:0] glyph_sel;
  logic [tcw_pkg::LIN_W-1:0]  cell_lin;
  logic [tcw_pkg::LIN_W-1:0]  pos_lin;

  assign cfg_ready = 1'b1;

  // Take the head item when the result register is free or draining
  assign pop = head.valid && (!res_valid || !res_stall);

  // Write cell uses the cursor before the move, except for backspace
  always_comb begin
    row_step  = {1'b0, cursor_row};
    col_step  = {1'b0, cursor_column};
    wr        = 1'b1;
    glyph_sel = head.item.code;
    unique case (head.item.op)
      tcw_pkg::OP_NEWLINE: begin
        row_step = {1'b0, cursor_row} + (tcw_pkg::ROW_W+1)'(1);
        col_step = '0;
        wr       = 1'b0;
      end
      tcw_pkg::OP_BACKSPACE: begin
        glyph_sel = tcw_pkg::CODE_SPACE;
        if (cursor_column != '0) begin
          col_step = {1'b0, cursor_column} - (tcw_pkg::COL_W+1)'(1);
        end else if (cursor_row != '0) begin
          row_step = {1'b0, cursor_row} - (tcw_pkg::ROW_W+1)'(1);
          col_step = (tcw_pkg::COL_W+1)'(tcw_pkg::COLUMNS - 1);
        end
      end
      default: begin
        col_step = {1'b0, cursor_column} + (tcw_pkg::COL_W+1)'(1);
        if (col_step >= (tcw_pkg::COL_W+1)'(tcw_pkg::COLUMNS)) begin
          col_step = '0;
          row_step = {1'b0, cursor_row} + (tcw_pkg::ROW_W+1)'(1);
        end
      end
    endcase
  end

  // Cell address: backspace writes at the moved-to cell, print at the old one
  always_comb begin
    if (head.item.op == tcw_pkg::OP_BACKSPACE) begin
      cell_lin = tcw_pkg::LIN_W'(row_step[tcw_pkg::ROW_W-1:0])
               * tcw_pkg::LIN_W'(tcw_pkg::COLUMNS)
               + tcw_pkg::LIN_W'(col_step[tcw_pkg::COL_W-1:0]);
    end else begin
      cell_lin = tcw_pkg::LIN_W'(cursor_row) * tcw_pkg::LIN_W'(tcw_pkg::COLUMNS)
               + tcw_pkg::LIN_W'(cursor_column);
    end
  end

  // Bottom passed: clear and home
  always_comb begin
    clr                = (row_step >= (tcw_pkg::ROW_W+1)'(tcw_pkg::ROWS));
    cursor_row_next    = clr ? '0 : row_step[tcw_pkg::ROW_W-1:0];
    cursor_column_next = clr ? '0 : col_step[tcw_pkg::COL_W-1:0];
    pos_lin            = tcw_pkg::LIN_W'(cursor_row_next)
                       * tcw_pkg::LIN_W'(tcw_pkg::COLUMNS)
                       + tcw_pkg::LIN_W'(cursor_column_next);
  end

  // Control state: attribute, cursor, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      attr_reg      <= tcw_pkg::ATTR_RESET;
      cursor_row    <= '0;
      cursor_column <= '0;
      res_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        attr_reg <= text_attribute;
      end
      if (pop) begin
        cursor_row    <= cursor_row_next;
        cursor_column <= cursor_column_next;
        res_valid     <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      write_valid     <= wr;
      cell_index      <= wr ? cell_lin[tcw_pkg::IDX_W-1:0] : '0;
      glyph           <= wr ? glyph_sel : '0;
      attribute       <= wr ? attr_reg : '0;
      clear_request   <= clr;
      cursor_position <= pos_lin[tcw_pkg::IDX_W-1:0];
    end
  end

endmodule

/* design/text_console_character_writer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_character_writer_top - teletype-style text console writer
// Turns a stream of character codes into cell writes and cursor updates.
//
//   channel  handshake              payload
//   char     char_valid/char_stall  char_code
//   cfg      cfg_valid/cfg_ready    text_attribute
//   res      res_valid/res_stall    write_valid, cell_index, glyph, attribute,
//                                   clear_request, cursor_position
//
// One item per cycle sustained while res is not stalled; an accepted item is
// written into the queue, and the result register loads as it leaves the queue.
// The cursor update is the feedback loop; multiplies by COLUMNS feed only res.
// Synchronous reset homes the cursor, empties the queue, sets attribute 0x0F.
// The two-entry queue lets input keep flowing for two items while res stalls.
// ----------------------------------------------------------------------------
module text_console_character_writer_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       char_valid,
  output logic                       char_stall,
  input  logic [tcw_pkg::CODE_W-1:0] char_code,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [tcw_pkg::ATTR_W-1:0] text_attribute,
  output logic                       res_valid,
  input  logic                       res_stall,
  output logic                       write_valid,
  output logic [tcw_pkg::IDX_W-1:0]  cell_index,
  output logic [tcw_pkg::CODE_W-1:0] glyph,
  output logic [tcw_pkg::ATTR_W-1:0] attribute,
  output logic                       clear_request,
  output logic [tcw_pkg::IDX_W-1:0]  cursor_position
);

  logic            q_full;
  logic            q_push;
  logic            q_pop;
  tcw_pkg::item_t  q_item;
  tcw_pkg::q_out_t q_head;

  // Front end: classify and enqueue
  tcw_front u_front (
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_code  (char_code),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (q_item)
  );

  // Decoupling queue
  tcw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head)
  );

  // Back end: cursor engine and result register
  tcw_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (q_head),
    .pop             (q_pop),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .text_attribute  (text_attribute),
    .res_valid       (res_valid),
    .res_stall       (res_stall),
    .write_valid     (write_valid),
    .cell_index      (cell_index),
    .glyph           (glyph),
    .attribute       (attribute),
    .clear_request   (clear_request),
    .cursor_position (cursor_position)
  );

endmodule
